### hdl/hck_pkg.sv
// ----------------------------------------------------------------------------
// hck_pkg
// shared types and codes of the hex calculator key engine
// ----------------------------------------------------------------------------
package hck_pkg;

    localparam int WordBits = 32;

    typedef enum logic [1:0] {
        MODE_DIGIT = 2'd0,
        MODE_BKSP  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_OPER  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        OP_EQ  = 4'd0,
        OP_ADD = 4'd1,
        OP_SUB = 4'd2,
        OP_MUL = 4'd3,
        OP_AND = 4'd4,
        OP_OR  = 4'd5,
        OP_XOR = 4'd6,
        OP_SHL = 4'd7,
        OP_SHR = 4'd8,
        OP_DIV = 4'd9,
        OP_MOD = 4'd10
    } oper_t;

    typedef struct packed {
        logic       start;
        logic [3:0] op;
    } alu_ctl_t;

endpackage

### hdl/hck_alu.sv
// ----------------------------------------------------------------------------
// hck_alu
// bit-serial arithmetic unit: one result bit or one operand bit per cycle
// ----------------------------------------------------------------------------
module hck_alu
    import hck_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  alu_ctl_t            ctl,
    input  logic [WordBits-1:0] a,
    input  logic [WordBits-1:0] b,
    output logic                done,
    output logic [WordBits-1:0] result
);

    localparam int CntBits = $clog2(WordBits + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } st_t;

    st_t                 state_reg, state_next;
    logic [CntBits-1:0]  cnt_reg, cnt_next;
    logic [3:0]          op_reg, op_next;
    logic [WordBits-1:0] a_reg, a_next;     // shifts out lsb first (add/sub) or msb first (div)
    logic [WordBits-1:0] b_reg, b_next;
    logic [WordBits-1:0] acc_reg, acc_next; // result / quotient
    logic [WordBits:0]   rem_reg, rem_next; // remainder
    logic                carry_reg, carry_next;
    logic                big_shift;
    logic [WordBits:0]   rem_sh;
    logic [WordBits:0]   rem_sub;
    logic                s_bit, c_bit, bb;

    assign big_shift = (b >= WordBits'(WordBits));
    assign rem_sh    = {rem_reg[WordBits-1:0], a_reg[WordBits-1]};
    assign rem_sub   = rem_sh - {1'b0, b_reg};
    assign bb        = (op_reg == OP_SUB) ? ~b_reg[0] : b_reg[0];
    assign s_bit     = a_reg[0] ^ bb ^ carry_reg;
    assign c_bit     = (a_reg[0] & bb) | (carry_reg & (a_reg[0] ^ bb));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        carry_next = carry_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = ST_RUN;
                    cnt_next   = CntBits'(WordBits);
                    op_next    = ctl.op;
                    a_next     = a;
                    b_next     = b;
                    acc_next   = '0;
                    rem_next   = '0;
                    carry_next = (ctl.op == OP_SUB);
                    // single-step operations finish without iteration
                    case (ctl.op)
                        OP_EQ:  begin acc_next = b;     state_next = ST_DONE; end
                        OP_AND: begin acc_next = a & b; state_next = ST_DONE; end
                        OP_OR:  begin acc_next = a | b; state_next = ST_DONE; end
                        OP_XOR: begin acc_next = a ^ b; state_next = ST_DONE; end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: ;
                        OP_SHL, OP_SHR:
                        begin
                            if (big_shift)
                            begin
                                acc_next   = '0;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                acc_next = a;
                                cnt_next = CntBits'(b);
                                if (b == '0)
                                    state_next = ST_DONE;
                            end
                        end
                        default: begin acc_next = '0; state_next = ST_DONE; end
                    endcase
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CntBits'(1))
                    state_next = ST_DONE;
                case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        acc_next   = {s_bit, acc_reg[WordBits-1:1]};
                        carry_next = c_bit;
                        a_next     = a_reg >> 1;
                        b_next     = b_reg >> 1;
                    end
                    OP_MUL:
                    begin
                        // a holds the shifted multiplicand, b is scanned lsb first
                        if (b_reg[0])
                            acc_next = acc_reg + a_reg;
                        a_next = a_reg << 1;
                        b_next = b_reg >> 1;
                    end
                    OP_SHL: acc_next = acc_reg << 1;
                    OP_SHR: acc_next = acc_reg >> 1;
                    default:
                    begin
                        // restoring division, one quotient bit per cycle
                        a_next = a_reg << 1;
                        if (!rem_sub[WordBits])
                        begin
                            rem_next = rem_sub;
                            acc_next = {acc_reg[WordBits-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = rem_sh;
                            acc_next = {acc_reg[WordBits-2:0], 1'b0};
                        end
                    end
                endcase
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        carry_reg <= carry_next;
    end

    assign done = (state_reg == ST_DONE);

    always_comb
    begin
        if ((op_reg == OP_DIV || op_reg == OP_MOD) && b_reg == '0)
            result = '1;
        else if (op_reg == OP_MOD)
            result = rem_reg[WordBits-1:0];
        else
            result = acc_reg;
    end

endmodule

### hdl/hex_calculator_key_engine.sv
// ----------------------------------------------------------------------------
// hex_calculator_key_engine
// hexadecimal calculator keypress engine with a bit-serial arithmetic unit
// ----------------------------------------------------------------------------
// channel  dir  signals                                    payload
// s_axis   in   tvalid tready tdata[7:0] tuser[1:0]        digit, operator / mode
// m_axis   out  tvalid tready tdata[31:0] tuser            display / rejected
//
// digit, backspace and clear keys, and an operator key with no digit entered
// since reset or the last operator, allow the result transfer in the cycle
// after the input transfer. other operator keys run through the serial unit:
// add/sub/mul/div/mod iterate over the operand bits, shifts iterate over the
// shift count (no iteration for a count of 32 or more), and/or/xor/equals
// and unknown codes finish without iteration.
// one key at a time; s_axis_tready returns in the cycle after the result
// transfer and a stalled result holds it low.
// rst_n clears the entry, operand and pending operator asynchronously.
// ----------------------------------------------------------------------------
module hex_calculator_key_engine
    import hck_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // digit[3:0], operator[7:4]
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // display[31:0]
    output logic        m_axis_tuser    // rejected
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ALU  = 3'b010,
        ST_OUT  = 3'b100
    } st_t;

    st_t                 state_reg;
    logic [WordBits-1:0] entry_reg;
    logic [WordBits-1:0] first_reg;
    logic [3:0]          pend_reg;
    logic                newnum_reg;
    logic                rej_reg;
    logic                in_xfer;
    logic [1:0]          mode;
    logic [3:0]          digit;
    logic [3:0]          oper;
    alu_ctl_t            alu_ctl;
    logic                alu_done;
    logic [WordBits-1:0] alu_result;
    logic [WordBits-1:0] dig_base;

    assign mode  = s_axis_tuser;
    assign digit = s_axis_tdata[3:0];
    assign oper  = s_axis_tdata[7:4];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = entry_reg[31:0];
    assign m_axis_tuser  = rej_reg;

    assign alu_ctl.start = in_xfer && (mode == MODE_OPER) && !newnum_reg;
    assign alu_ctl.op    = pend_reg;
    assign dig_base      = newnum_reg ? '0 : entry_reg;

    hck_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (alu_ctl),
        .a      (first_reg),
        .b      (entry_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            entry_reg  <= '0;
            first_reg  <= '0;
            pend_reg   <= OP_EQ;
            newnum_reg <= 1'b1;
            rej_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        rej_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                        unique case (mode)
                            MODE_DIGIT:
                            begin
                                if (newnum_reg)
                                    first_reg <= entry_reg;
                                newnum_reg <= 1'b0;
                                if (dig_base[WordBits-1:WordBits-4] == 4'd0)
                                    entry_reg <= {dig_base[WordBits-5:0], digit};
                                else
                                begin
                                    entry_reg <= dig_base;
                                    rej_reg   <= 1'b1;
                                end
                            end
                            MODE_BKSP:  entry_reg <= entry_reg >> 4;
                            MODE_CLEAR: entry_reg <= '0;
                            default:
                            begin
                                if (!newnum_reg)
                                    state_reg <= ST_ALU;
                                newnum_reg <= 1'b1;
                                pend_reg   <= oper;
                            end
                        endcase
                    end
                end
                ST_ALU:
                begin
                    if (alu_done)
                    begin
                        entry_reg <= alu_result;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_axis_tready)
        else $error("key accepted while busy");
    a_rej_digit: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && mode != MODE_DIGIT |=> !rej_reg)
        else $error("reject flag on non-digit key");

endmodule
